// ===== rtl/brs_pkg.sv =====
// brs_pkg: shared types and constants of the bitstream randomness statistics unit
// no dependencies; imported by brs_bit_stats, brs_stats_core, the top level and the testbench

package brs_pkg;

  // operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } brs_func_e;

  // statistics table selected by a read
  typedef enum logic [1:0] {
    TBL_BYTE   = 2'd0,
    TBL_POKER  = 2'd1,
    TBL_RUN    = 2'd2,
    TBL_SCALAR = 2'd3
  } brs_table_e;

  // entries of the scalar counter table
  typedef enum logic [1:0] {
    SCL_BITS  = 2'd0,
    SCL_ONES  = 2'd1,
    SCL_TRANS = 2'd2,
    SCL_MATCH = 2'd3
  } brs_scalar_e;

  localparam int unsigned BYTE_DEPTH   = 256;
  localparam int unsigned BYTE_AW      = $clog2(BYTE_DEPTH);
  localparam int unsigned POKER_DEPTH  = 16;
  localparam int unsigned POKER_AW     = $clog2(POKER_DEPTH);
  localparam int unsigned RUN_DEPTH    = 4;
  localparam int unsigned RUN_AW       = $clog2(RUN_DEPTH);
  localparam int unsigned SCALAR_DEPTH = 4;
  localparam int unsigned VALUE_W      = 32;

  // one input word as held in the work stage
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [1:0] table_select;
    logic [7:0] entry_index;
  } brs_item_t;

  // one result word
  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               index_error;
    logic               saturated;
  } brs_result_t;

  // per-byte statistics handed from the bit decoder to the counter bank
  typedef struct packed {
    logic [3:0]        ones_cnt;
    logic [3:0]        trans_cnt;
    logic [3:0]        match_cnt;
    logic [POKER_AW-1:0] poker_lo;
    logic [POKER_AW-1:0] poker_hi;
    logic [RUN_AW-1:0]   run_bucket;
    logic              last_bit;
  } brs_byte_info_t;

endpackage

// ===== rtl/brs_in_if.sv =====
// brs_in_if: valid/ready channel carrying one input word
// depends on nothing; used by the top level and its environment

interface brs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic [1:0] table_select;
  logic [7:0] entry_index;

  modport source (
    output valid, func, data_byte, table_select, entry_index,
    input  ready
  );

  modport sink (
    input  valid, func, data_byte, table_select, entry_index,
    output ready
  );
endinterface

// ===== rtl/brs_out_if.sv =====
// brs_out_if: valid/ready channel carrying one result word
// depends on nothing; used by the top level and its environment

interface brs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        index_error;
  logic        saturated;

  modport source (
    output valid, read_value, index_error, saturated,
    input  ready
  );

  modport sink (
    input  valid, read_value, index_error, saturated,
    output ready
  );
endinterface

// ===== rtl/bitstream_randomness_statistics_unit.sv =====
// bitstream_randomness_statistics_unit: top level, two-stage word pipeline around the counter bank
// depends on brs_pkg, brs_in_if, brs_out_if and brs_stats_core
//
//   channel | dir | modport  | payload
//   in_i    | in  | sink     | func, data_byte, table_select, entry_index
//   out_o   | out | source   | read_value, index_error, saturated
//
// one word per clock sustained while the output is not stalled; a taken word is held in the work stage,
// then its result in the output register; the histogram read-modify-write reads the ram on entry,
// writes it on exit, with a bypass when consecutive words hit the same entry
// reset clears every counter and the histogram valid bits at once, no sweep
// a stalled output holds its result; the work stage keeps taking words until it fills

module bitstream_randomness_statistics_unit import brs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  brs_in_if.sink    in_i,
  brs_out_if.source out_o
);

  logic        accept;
  logic        out_free;
  logic        s1_adv;
  brs_item_t   in_item;
  logic        s1_valid_q;
  brs_item_t   s1_item_q;
  logic        out_valid_q;
  brs_result_t out_res_q;
  brs_result_t core_res;

  // handshake between the stages
  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_adv    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign accept    = in_i.valid && in_i.ready;

  assign in_item.func         = in_i.func;
  assign in_item.data_byte    = in_i.data_byte;
  assign in_item.table_select = in_i.table_select;
  assign in_item.entry_index  = in_i.entry_index;

  // work stage and output register, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // work stage and output register, payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      out_res_q <= core_res;
    end
  end

  brs_stats_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i ((in_i.func == FUNC_ADD) ? in_i.data_byte : in_i.entry_index),
    .commit_i  (s1_adv),
    .item_i    (s1_item_q),
    .result_o  (core_res)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = out_res_q.read_value;
  assign out_o.index_error = out_res_q.index_error;
  assign out_o.saturated   = out_res_q.saturated;

endmodule

// ===== rtl/brs_ram.sv =====
// brs_ram: generic single write port, single read port ram with registered read
// no dependencies

module brs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/brs_bit_stats.sv =====
// brs_bit_stats: decodes one stream byte into ones, neighbour pairs, poker blocks and run bucket
// depends on brs_pkg

module brs_bit_stats import brs_pkg::*; (
  input  logic           [7:0] data_byte_i,
  input  logic                 prev_bit_i,
  input  logic                 have_prev_i,
  output brs_byte_info_t       info_o
);

  logic [6:0] diff;
  logic [2:0] inner_trans;
  logic [3:0] ones;
  logic       edge_diff;
  logic [6:0] run2;
  logic [5:0] run3;
  logic [4:0] run4;

  // ones count and transitions inside the byte
  always_comb begin
    ones        = '0;
    inner_trans = '0;
    diff        = data_byte_i[7:1] ^ data_byte_i[6:0];
    for (int i = 0; i < 8; i++) begin
      ones = ones + 4'(data_byte_i[i]);
    end
    for (int i = 0; i < 7; i++) begin
      inner_trans = inner_trans + 3'(diff[i]);
    end
  end

  // pair across the byte boundary, only once a bit has been seen
  assign edge_diff = data_byte_i[0] ^ prev_bit_i;

  // runs of two, three and four ones anywhere in the byte
  assign run2 = data_byte_i[6:0] & data_byte_i[7:1];
  assign run3 = run2[5:0] & data_byte_i[7:2];
  assign run4 = run3[4:0] & data_byte_i[7:3];

  always_comb begin
    info_o.ones_cnt  = ones;
    info_o.trans_cnt = 4'(inner_trans) + 4'(have_prev_i & edge_diff);
    info_o.match_cnt = (4'd7 - 4'(inner_trans)) + 4'(have_prev_i & ~edge_diff);
    // earliest bit lands in the most significant place of each block
    info_o.poker_lo  = {data_byte_i[0], data_byte_i[1], data_byte_i[2], data_byte_i[3]};
    info_o.poker_hi  = {data_byte_i[4], data_byte_i[5], data_byte_i[6], data_byte_i[7]};
    info_o.last_bit  = data_byte_i[7];
    priority if (|run4) begin
      info_o.run_bucket = RUN_AW'(3);
    end else if (|run3) begin
      info_o.run_bucket = RUN_AW'(2);
    end else if (|run2) begin
      info_o.run_bucket = RUN_AW'(1);
    end else begin
      info_o.run_bucket = RUN_AW'(0);
    end
  end

endmodule

// ===== rtl/brs_stats_core.sv =====
// brs_stats_core: counter bank, byte histogram ram with bypass, and result formation
// depends on brs_pkg, brs_ram and brs_bit_stats

module brs_stats_core import brs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [BYTE_AW-1:0] rd_addr_i,
  input  logic               commit_i,
  input  brs_item_t          item_i,
  output brs_result_t        result_o
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  localparam int unsigned SumW   = COUNT_WIDTH + 1;
  localparam cnt_t        CntMax = '1;

  // saturating add of a small increment
  function automatic cnt_t sat_add(input cnt_t v, input logic [3:0] inc);
    logic [SumW-1:0] sum;
    sum = SumW'(v) + SumW'(inc);
    if (sum >= SumW'(CntMax)) begin
      return CntMax;
    end
    return sum[COUNT_WIDTH-1:0];
  endfunction

  brs_byte_info_t     info;
  logic               is_add;
  logic               is_read;
  logic [BYTE_AW-1:0] hist_addr;
  cnt_t               ram_rdata;
  cnt_t               hist_cur;
  cnt_t               hist_new;
  logic               hist_we;

  logic [BYTE_DEPTH-1:0] hist_valid_q, hist_valid_d;
  logic                  fwd_q;
  cnt_t                  fwd_data_q;

  cnt_t poker_q [POKER_DEPTH];
  cnt_t poker_d [POKER_DEPTH];
  cnt_t run_q   [RUN_DEPTH];
  cnt_t run_d   [RUN_DEPTH];
  cnt_t bits_q, bits_d;
  cnt_t ones_q, ones_d;
  cnt_t trans_q, trans_d;
  cnt_t match_q, match_d;
  logic prev_bit_q, prev_bit_d;
  logic have_prev_q, have_prev_d;
  logic flag_q, flag_d;

  cnt_t value;
  logic err;

  brs_bit_stats u_bit_stats (
    .data_byte_i (item_i.data_byte),
    .prev_bit_i  (prev_bit_q),
    .have_prev_i (have_prev_q),
    .info_o      (info)
  );

  assign is_add    = (item_i.func == FUNC_ADD);
  assign is_read   = (item_i.func == FUNC_READ);
  assign hist_addr = is_add ? item_i.data_byte : item_i.entry_index;
  assign hist_we   = commit_i && is_add;

  // byte histogram storage, read as the word enters, written as it leaves
  brs_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (item_i.data_byte),
    .wdata_i (hist_new),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // entry value: bypassed write, or ram data if written since clear
  assign hist_cur = fwd_q ? fwd_data_q : (hist_valid_q[hist_addr] ? ram_rdata : '0);
  assign hist_new = sat_add(hist_cur, 4'd1);

  // bypass when the word ahead writes the entry now being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= hist_we && (rd_addr_i == item_i.data_byte);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= hist_new;
    end
  end

  // next state of every counter
  always_comb begin
    hist_valid_d = hist_valid_q;
    poker_d      = poker_q;
    run_d        = run_q;
    bits_d       = bits_q;
    ones_d       = ones_q;
    trans_d      = trans_q;
    match_d      = match_q;
    prev_bit_d   = prev_bit_q;
    have_prev_d  = have_prev_q;
    flag_d       = flag_q;
    unique case (item_i.func)
      FUNC_ADD: begin
        hist_valid_d[item_i.data_byte] = 1'b1;
        if (hist_new == CntMax) flag_d = 1'b1;
        for (int k = 0; k < POKER_DEPTH; k++) begin
          if ((info.poker_lo == POKER_AW'(k)) || (info.poker_hi == POKER_AW'(k))) begin
            poker_d[k] = sat_add(poker_q[k],
                                 4'(info.poker_lo == POKER_AW'(k)) +
                                 4'(info.poker_hi == POKER_AW'(k)));
            if (poker_d[k] == CntMax) flag_d = 1'b1;
          end
        end
        run_d[info.run_bucket] = sat_add(run_q[info.run_bucket], 4'd1);
        if (run_d[info.run_bucket] == CntMax) flag_d = 1'b1;
        bits_d  = sat_add(bits_q, 4'd8);
        ones_d  = sat_add(ones_q, info.ones_cnt);
        trans_d = sat_add(trans_q, info.trans_cnt);
        match_d = sat_add(match_q, info.match_cnt);
        if ((bits_d == CntMax) || (ones_d == CntMax) ||
            (trans_d == CntMax) || (match_d == CntMax)) begin
          flag_d = 1'b1;
        end
        prev_bit_d  = info.last_bit;
        have_prev_d = 1'b1;
      end
      FUNC_CLEAR: begin
        hist_valid_d = '0;
        for (int k = 0; k < POKER_DEPTH; k++) poker_d[k] = '0;
        for (int k = 0; k < RUN_DEPTH; k++) run_d[k] = '0;
        bits_d      = '0;
        ones_d      = '0;
        trans_d     = '0;
        match_d     = '0;
        prev_bit_d  = 1'b0;
        have_prev_d = 1'b0;
        flag_d      = 1'b0;
      end
      default: ;
    endcase
  end

  // counter registers, updated as the word leaves the work stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_valid_q <= '0;
      for (int k = 0; k < POKER_DEPTH; k++) poker_q[k] <= '0;
      for (int k = 0; k < RUN_DEPTH; k++) run_q[k] <= '0;
      bits_q      <= '0;
      ones_q      <= '0;
      trans_q     <= '0;
      match_q     <= '0;
      prev_bit_q  <= 1'b0;
      have_prev_q <= 1'b0;
      flag_q      <= 1'b0;
    end else if (commit_i) begin
      hist_valid_q <= hist_valid_d;
      poker_q      <= poker_d;
      run_q        <= run_d;
      bits_q       <= bits_d;
      ones_q       <= ones_d;
      trans_q      <= trans_d;
      match_q      <= match_d;
      prev_bit_q   <= prev_bit_d;
      have_prev_q  <= have_prev_d;
      flag_q       <= flag_d;
    end
  end

  // entry lookup for reads
  always_comb begin
    value = '0;
    err   = 1'b0;
    if (is_read) begin
      unique case (item_i.table_select)
        TBL_BYTE: value = hist_cur;
        TBL_POKER: begin
          if (item_i.entry_index < 8'(POKER_DEPTH)) begin
            value = poker_q[item_i.entry_index[POKER_AW-1:0]];
          end else begin
            err = 1'b1;
          end
        end
        TBL_RUN: begin
          if (item_i.entry_index < 8'(RUN_DEPTH)) begin
            value = run_q[item_i.entry_index[RUN_AW-1:0]];
          end else begin
            err = 1'b1;
          end
        end
        TBL_SCALAR: begin
          if (item_i.entry_index < 8'(SCALAR_DEPTH)) begin
            unique case (item_i.entry_index[1:0])
              SCL_BITS:  value = bits_q;
              SCL_ONES:  value = ones_q;
              SCL_TRANS: value = trans_q;
              SCL_MATCH: value = match_q;
              default:   value = '0;
            endcase
          end else begin
            err = 1'b1;
          end
        end
        default: value = '0;
      endcase
    end
  end

  assign result_o.read_value  = VALUE_W'(value);
  assign result_o.index_error = err;
  assign result_o.saturated   = flag_d;

endmodule

// ===== tb/bitstream_randomness_statistics_unit_tb.sv =====
`timescale 1ns / 1ps
// bitstream_randomness_statistics_unit_tb: self-checking bench for the statistics unit
// depends on brs_pkg, brs_in_if, brs_out_if and bitstream_randomness_statistics_unit

module bitstream_randomness_statistics_unit_tb;
  import brs_pkg::*;

  // counter width of the unit under test
  localparam int unsigned      CNT_W        = 16;
  localparam logic [CNT_W-1:0] CNT_TOP      = {CNT_W{1'b1}};
  localparam logic [1:0]       FUNC_SPARE   = 2'd3;
  localparam int unsigned      RANDOM_WORDS = 720;
  localparam int unsigned      CALM_TAIL    = 150;
  localparam int unsigned      HOLD_AT      = 300;
  localparam int unsigned      HOLD_LEN     = 80;
  localparam int unsigned      DRAIN_CYCLES = 10;
  localparam int unsigned      CYCLE_LIMIT  = 1_000_000;

  logic clk_i;
  logic rst_ni;

  brs_in_if  in_ch ();
  brs_out_if out_ch ();

  bitstream_randomness_statistics_unit #(
    .COUNT_WIDTH(CNT_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // shadow copy of the statistics
  logic [CNT_W-1:0] byte_hist  [BYTE_DEPTH];
  logic [CNT_W-1:0] poker_hist [POKER_DEPTH];
  logic [CNT_W-1:0] run_hist   [RUN_DEPTH];
  logic [CNT_W-1:0] bit_cnt, ones_cnt, trans_cnt, match_cnt;
  logic             last_bit, seen_bit, sticky_sat;

  brs_item_t   pending_words   [$];
  brs_result_t awaited_results [$];

  logic        word_taken   = 1'b0;
  int unsigned words_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  int unsigned cycle_cnt    = 0;

  task automatic clear_stats();
    foreach (byte_hist[i]) byte_hist[i] = '0;
    foreach (poker_hist[i]) poker_hist[i] = '0;
    foreach (run_hist[i]) run_hist[i] = '0;
    bit_cnt    = '0;
    ones_cnt   = '0;
    trans_cnt  = '0;
    match_cnt  = '0;
    last_bit   = 1'b0;
    seen_bit   = 1'b0;
    sticky_sat = 1'b0;
  endtask

  // saturating increment, raises the sticky flag whenever the top is reached
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cur,
                                               input int unsigned inc);
    logic [CNT_W-1:0] nxt;
    if (inc >= CNT_TOP - cur) nxt = CNT_TOP;
    else nxt = CNT_W'(cur + inc);
    if (nxt == CNT_TOP) sticky_sat = 1'b1;
    return nxt;
  endfunction

  // update the shadow statistics with one word and queue its result
  task automatic tally_word(input brs_item_t w);
    brs_result_t res;
    int unsigned n_ones, n_trans, n_match, run_len, best, i;
    logic [3:0]  lo_blk, hi_blk;
    logic [1:0]  bucket;
    logic        b;
    res = '0;
    case (w.func)
      FUNC_ADD: begin
        n_ones  = 0;
        n_trans = 0;
        n_match = 0;
        run_len = 0;
        best    = 0;
        // bits go least significant first, pairs carry across words
        for (i = 0; i < 8; i++) begin
          b = w.data_byte[i];
          if (seen_bit) begin
            if (b != last_bit) n_trans++;
            else n_match++;
          end
          last_bit = b;
          seen_bit = 1'b1;
          if (b) begin
            n_ones++;
            run_len++;
            if (run_len > best) best = run_len;
          end else begin
            run_len = 0;
          end
        end
        // earliest bit of a block is its most significant
        lo_blk = {w.data_byte[0], w.data_byte[1], w.data_byte[2], w.data_byte[3]};
        hi_blk = {w.data_byte[4], w.data_byte[5], w.data_byte[6], w.data_byte[7]};
        if (best <= 1) bucket = 2'd0;
        else if (best >= 4) bucket = 2'd3;
        else bucket = 2'(best - 1);
        byte_hist[w.data_byte] = sat_add(byte_hist[w.data_byte], 1);
        bit_cnt                = sat_add(bit_cnt, 8);
        ones_cnt               = sat_add(ones_cnt, n_ones);
        trans_cnt              = sat_add(trans_cnt, n_trans);
        match_cnt              = sat_add(match_cnt, n_match);
        poker_hist[lo_blk]     = sat_add(poker_hist[lo_blk], 1);
        poker_hist[hi_blk]     = sat_add(poker_hist[hi_blk], 1);
        run_hist[bucket]       = sat_add(run_hist[bucket], 1);
      end
      FUNC_READ: begin
        case (w.table_select)
          TBL_BYTE: res.read_value = 32'(byte_hist[w.entry_index]);
          TBL_POKER: begin
            if (w.entry_index < POKER_DEPTH)
              res.read_value = 32'(poker_hist[w.entry_index[POKER_AW-1:0]]);
            else res.index_error = 1'b1;
          end
          TBL_RUN: begin
            if (w.entry_index < RUN_DEPTH)
              res.read_value = 32'(run_hist[w.entry_index[RUN_AW-1:0]]);
            else res.index_error = 1'b1;
          end
          default: begin
            if (w.entry_index < SCALAR_DEPTH) begin
              case (w.entry_index[1:0])
                SCL_BITS:  res.read_value = 32'(bit_cnt);
                SCL_ONES:  res.read_value = 32'(ones_cnt);
                SCL_TRANS: res.read_value = 32'(trans_cnt);
                default:   res.read_value = 32'(match_cnt);
              endcase
            end else begin
              res.index_error = 1'b1;
            end
          end
        endcase
      end
      FUNC_CLEAR: clear_stats();
      default: ;
    endcase
    res.saturated = sticky_sat;
    awaited_results.insert(awaited_results.size(), res);
  endtask

  task automatic queue_word(input logic [1:0] f, input logic [7:0] d,
                            input logic [1:0] t, input logic [7:0] e);
    brs_item_t w;
    w.func         = f;
    w.data_byte    = d;
    w.table_select = t;
    w.entry_index  = e;
    pending_words.insert(pending_words.size(), w);
  endtask

  // clock and known levels on every input from time zero
  initial begin
    clk_i               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_ADD;
    in_ch.data_byte     = '0;
    in_ch.table_select  = TBL_BYTE;
    in_ch.entry_index   = '0;
    out_ch.ready        = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned pick, lim, n;
    logic [1:0]  f, t;
    logic [7:0]  e;
    rst_ni = 1'b0;
    clear_stats();

    // empty tables, out-of-range reads
    queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'(SCL_BITS));
    queue_word(FUNC_READ, 8'h00, TBL_BYTE, 8'd255);
    queue_word(FUNC_READ, 8'h00, TBL_POKER, 8'd16);
    queue_word(FUNC_READ, 8'h00, TBL_RUN, 8'd4);
    queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'd4);
    queue_word(FUNC_READ, 8'h00, TBL_POKER, 8'd255);
    // first bit forms no pair
    queue_word(FUNC_ADD, 8'h01, TBL_BYTE, 8'd0);
    queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'(SCL_TRANS));
    // extremes, alternating patterns and each run bucket
    queue_word(FUNC_ADD, 8'h00, TBL_BYTE, 8'd0);
    queue_word(FUNC_ADD, 8'hFF, TBL_BYTE, 8'd0);
    queue_word(FUNC_ADD, 8'h55, TBL_BYTE, 8'd0);
    queue_word(FUNC_ADD, 8'hAA, TBL_BYTE, 8'd0);
    queue_word(FUNC_ADD, 8'h6E, TBL_BYTE, 8'd0);
    queue_word(FUNC_ADD, 8'h36, TBL_BYTE, 8'd0);
    queue_word(FUNC_ADD, 8'h0F, TBL_BYTE, 8'd0);
    // unused code leaves everything alone
    queue_word(FUNC_SPARE, 8'hFF, TBL_SCALAR, 8'd0);
    queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'(SCL_ONES));
    queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'(SCL_MATCH));
    queue_word(FUNC_READ, 8'h00, TBL_POKER, 8'd8);
    queue_word(FUNC_READ, 8'h00, TBL_RUN, 8'd3);
    queue_word(FUNC_READ, 8'h00, TBL_BYTE, 8'h55);
    // clear, then the first bit again
    queue_word(FUNC_CLEAR, 8'h00, TBL_BYTE, 8'd0);
    queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'(SCL_BITS));
    queue_word(FUNC_ADD, 8'h80, TBL_BYTE, 8'd0);
    queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'(SCL_TRANS));
    for (n = 0; n < SCALAR_DEPTH; n++)
      queue_word(FUNC_READ, 8'h00, TBL_SCALAR, 8'(n));

    // random mix, mostly adds and reads
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) f = FUNC_ADD;
      else if (pick < 88) f = FUNC_READ;
      else if (pick < 91) f = FUNC_CLEAR;
      else f = FUNC_SPARE;
      t = 2'($urandom_range(0, 3));
      case (t)
        TBL_BYTE:  lim = BYTE_DEPTH - 1;
        TBL_POKER: lim = POKER_DEPTH - 1;
        TBL_RUN:   lim = RUN_DEPTH - 1;
        default:   lim = SCALAR_DEPTH - 1;
      endcase
      if ($urandom_range(0, 4) == 0) e = 8'($urandom_range(0, 255));
      else e = 8'($urandom_range(0, lim));
      queue_word(f, 8'($urandom_range(0, 255)), t, e);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // word driver: holds an offered word until taken, idles in random bursts
  always @(negedge clk_i) begin
    logic offer, just_taken;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      just_taken = word_taken;
      if (word_taken) begin
        void'(pending_words.pop_front());
        word_taken = 1'b0;
      end
      if (in_ch.valid && !just_taken) begin
        offer = 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
        offer = 1'b0;
      end else if (pending_words.size() == 0) begin
        offer = 1'b0;
      end else if (pending_words.size() > CALM_TAIL && hold_left == 0 &&
                   (words_taken / 120) % 3 != 2 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 17);
        offer    = 1'b0;
      end else begin
        offer = 1'b1;
      end
      in_ch.valid <= offer;
      if (offer) begin
        in_ch.func         <= pending_words[0].func;
        in_ch.data_byte    <= pending_words[0].data_byte;
        in_ch.table_select <= pending_words[0].table_select;
        in_ch.entry_index  <= pending_words[0].entry_index;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off to back the unit up
  always @(negedge clk_i) begin
    logic rdy;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      rdy       = 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      rdy = 1'b0;
    end else if (pending_words.size() > CALM_TAIL && (results_seen / 150) % 3 != 1 &&
                 $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 17);
      rdy      = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ch.ready <= rdy;
  end

  // monitor: predict on each taken word, check each delivered result
  always @(posedge clk_i) begin
    brs_item_t   w;
    brs_result_t exp_res;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        w.func         = in_ch.func;
        w.data_byte    = in_ch.data_byte;
        w.table_select = in_ch.table_select;
        w.entry_index  = in_ch.entry_index;
        tally_word(w);
        word_taken = 1'b1;
        words_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result word with nothing awaited");
          mismatches++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_ch.read_value !== exp_res.read_value) begin
            $error("read_value: expected %0h, got %0h", exp_res.read_value,
                   out_ch.read_value);
            mismatches++;
          end
          if (out_ch.index_error !== exp_res.index_error) begin
            $error("index_error: expected %0b, got %0b", exp_res.index_error,
                   out_ch.index_error);
            mismatches++;
          end
          if (out_ch.saturated !== exp_res.saturated) begin
            $error("saturated: expected %0b, got %0b", exp_res.saturated,
                   out_ch.saturated);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ===== bitstream_randomness_statistics_unit.f =====
rtl/brs_pkg.sv
rtl/brs_in_if.sv
rtl/brs_out_if.sv
rtl/brs_ram.sv
rtl/brs_bit_stats.sv
rtl/brs_stats_core.sv
rtl/bitstream_randomness_statistics_unit.sv
tb/bitstream_randomness_statistics_unit_tb.sv
